/* src/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master byte engine: command codes,
// phase codes, the input and result item records and the line-drive rules.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	localparam int BITS_PER_BYTE = 8;
	localparam int HP_W = 16;
	localparam logic [HP_W-1:0] HALF_PERIOD_RESET = 16'd5;

	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_READ  = 3'd4
	} cmd_t;

	typedef enum logic [3:0] {
		PH_IDLE        = 4'd0,
		PH_ST_SDA_REL  = 4'd1,
		PH_ST_SCL_REL  = 4'd2,
		PH_ST_SDA_LOW  = 4'd3,
		PH_ST_SCL_LOW  = 4'd4,
		PH_SP_SDA_LOW  = 4'd5,
		PH_SP_SCL_REL  = 4'd6,
		PH_SP_SDA_REL  = 4'd7,
		PH_BIT_LOW     = 4'd8,
		PH_BIT_HIGH    = 4'd9,
		PH_ACK_LOW     = 4'd10,
		PH_ACK_HIGH    = 4'd11,
		PH_FINAL       = 4'd12
	} phase_t;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
		logic       scl_in;
	} in_item_t;

	typedef struct packed {
		logic       scl_release;
		logic       sda_release;
		logic       busy_res;
		logic       accepted;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_seen;
	} out_item_t;

	// Line drives on the first tick of a phase; bit 1 is SCL, bit 0 is SDA.
	function automatic logic [1:0] phase_drive(
		input phase_t     p,
		input cmd_t       cmd,
		input logic [7:0] shift,
		input logic [3:0] bit_cnt,
		input logic       ack,
		input logic [1:0] cur
	);
		logic [1:0] d;
		logic [2:0] idx;
		d = cur;
		idx = 3'(BITS_PER_BYTE - 1) - bit_cnt[2:0];
		case (p)
			PH_ST_SDA_REL: d[0] = 1'b1;
			PH_ST_SCL_REL: d[1] = 1'b1;
			PH_ST_SDA_LOW: d[0] = 1'b0;
			PH_ST_SCL_LOW: d[1] = 1'b0;
			PH_SP_SDA_LOW: d[0] = 1'b0;
			PH_SP_SCL_REL: d[1] = 1'b1;
			PH_SP_SDA_REL: d[0] = 1'b1;
			PH_BIT_LOW: begin
				d[1] = 1'b0;
				d[0] = (cmd == CMD_WRITE) ? shift[idx] : 1'b1;
			end
			PH_BIT_HIGH: d[1] = 1'b1;
			PH_ACK_LOW: begin
				d[1] = 1'b0;
				d[0] = (cmd == CMD_READ) ? ~ack : 1'b1;
			end
			PH_ACK_HIGH: d[1] = 1'b1;
			default: d = 2'b01;
		endcase
		return d;
	endfunction

endpackage

/* src/i2cm_ifs.sv */
// ----------------------------------------------------------------------------
// i2cm channel interfaces
// Valid/ready channels for command ticks, results and the phase-length write.
// ----------------------------------------------------------------------------
interface i2cm_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] op;
	logic [7:0] tx_byte;
	logic       send_ack;
	logic       sda_in;
	logic       scl_in;

	modport source (output valid, op, tx_byte, send_ack, sda_in, scl_in, input ready);
	modport sink (input valid, op, tx_byte, send_ack, sda_in, scl_in, output ready);
endinterface

interface i2cm_out_if;
	logic       valid;
	logic       ready;
	logic       scl_release;
	logic       sda_release;
	logic       busy_res;
	logic       accepted;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_seen;

	modport source (output valid, scl_release, sda_release, busy_res, accepted, done_res,
		rx_byte, ack_seen, input ready);
	modport sink (input valid, scl_release, sda_release, busy_res, accepted, done_res,
		rx_byte, ack_seen, output ready);
endinterface

interface i2cm_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* src/i2c_master_byte_engine.sv */
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master tick engine: command ticks are registered, stepped through the
// phase sequencer and delivered as one registered result per tick.
//
// Channel   Dir  Contents
// in_ch     in   op, tx_byte, send_ack, sda_in, scl_in (one bus tick)
// out_ch    out  line releases, busy/accepted/done flags, rx_byte, ack_seen
// cfg_ch    in   half_period_ticks
//
// A request passes the input register and then the result register before its
// result is offered; one is accepted every cycle unless the result stalls, set
// by the single step of the phase sequencer between the registers.
// Reset releases both lines, clears the sequencer and loads a phase length of 5.
// A stalled result holds the pipeline; the input register takes one more request
// while the result register waits, and then the input stalls as well.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine (
	input  logic        clk,
	input  logic        arst_n,
	i2cm_in_if.sink     in_ch,
	i2cm_out_if.source  out_ch,
	i2cm_cfg_if.sink    cfg_ch
);
	import i2cm_pkg::*;

	logic            valid_s1;
	in_item_t        item_s1;
	logic            valid_s2;
	out_item_t       res_s2;
	out_item_t       res_next;
	logic [HP_W-1:0] half_period_q;
	logic            adv;

	assign adv = !valid_s2 || out_ch.ready;
	assign in_ch.ready = !valid_s1 || adv;
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RESET;
		end else if (cfg_ch.valid) begin
			half_period_q <= cfg_ch.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.op       <= in_ch.op;
			item_s1.tx_byte  <= in_ch.tx_byte;
			item_s1.send_ack <= in_ch.send_ack;
			item_s1.sda_in   <= in_ch.sda_in;
			item_s1.scl_in   <= in_ch.scl_in;
		end
		if (adv && valid_s1) begin
			res_s2 <= res_next;
		end
	end

	i2cm_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv && valid_s1),
		.item        (item_s1),
		.half_period (half_period_q),
		.res         (res_next)
	);

	assign out_ch.valid       = valid_s2;
	assign out_ch.scl_release = res_s2.scl_release;
	assign out_ch.sda_release = res_s2.sda_release;
	assign out_ch.busy_res    = res_s2.busy_res;
	assign out_ch.accepted    = res_s2.accepted;
	assign out_ch.done_res    = res_s2.done_res;
	assign out_ch.rx_byte     = res_s2.rx_byte;
	assign out_ch.ack_seen    = res_s2.ack_seen;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.accepted |-> res_s2.busy_res)
		else $error("accepted command did not leave the engine busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.done_res |-> !res_s2.busy_res && !res_s2.accepted)
		else $error("done reported while still busy");

	a_free_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ch.ready)
		else $error("input stalled while the result register is empty");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ch.ready |=> valid_s2 && $stable(res_s2))
		else $error("stalled result changed");

endmodule

/* src/i2cm_core.sv */
// ----------------------------------------------------------------------------
// i2cm_core
// Bus phase sequencer: holds the command state and advances it by one tick
// per enabled cycle, producing that tick's result.
// ----------------------------------------------------------------------------
module i2cm_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  i2cm_pkg::in_item_t    item,
	input  logic [15:0]           half_period,
	output i2cm_pkg::out_item_t   res
);
	import i2cm_pkg::*;

	phase_t     step_q, step_n;
	cmd_t       cmd_q, cmd_n;
	logic [3:0] bits_q, bits_n;
	logic [7:0] shift_q, shift_n;
	logic [HP_W-1:0] timer_q, timer_n;
	logic       ack_q, ack_n;
	logic [1:0] drive_q, drive_n;
	logic       last_ack_q, last_ack_n;
	logic [7:0] rx_q, rx_n;
	logic       acc, done;
	logic [HP_W-1:0] reload;
	phase_t     enter_p;
	logic       do_enter;

	assign reload = (half_period == '0) ? '0 : half_period - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= PH_IDLE;
			cmd_q      <= CMD_NONE;
			bits_q     <= '0;
			shift_q    <= '0;
			timer_q    <= '0;
			ack_q      <= 1'b0;
			drive_q    <= 2'b11;
			last_ack_q <= 1'b1;
			rx_q       <= '0;
		end else if (en) begin
			step_q     <= step_n;
			cmd_q      <= cmd_n;
			bits_q     <= bits_n;
			shift_q    <= shift_n;
			timer_q    <= timer_n;
			ack_q      <= ack_n;
			drive_q    <= drive_n;
			last_ack_q <= last_ack_n;
			rx_q       <= rx_n;
		end
	end

	always_comb begin
		step_n     = step_q;
		cmd_n      = cmd_q;
		bits_n     = bits_q;
		shift_n    = shift_q;
		timer_n    = timer_q;
		ack_n      = ack_q;
		last_ack_n = last_ack_q;
		rx_n       = rx_q;
		acc        = 1'b0;
		done       = 1'b0;
		do_enter   = 1'b0;
		enter_p    = PH_IDLE;
		case (step_q)
			PH_IDLE: begin
				if (item.op >= 3'(CMD_START) && item.op <= 3'(CMD_READ)) begin
					acc = 1'b1;
					cmd_n = cmd_t'(item.op);
					do_enter = 1'b1;
					if (item.op == 3'(CMD_START)) begin
						enter_p = PH_ST_SDA_REL;
					end else if (item.op == 3'(CMD_STOP)) begin
						enter_p = PH_SP_SDA_LOW;
					end else begin
						bits_n = '0;
						shift_n = (item.op == 3'(CMD_WRITE)) ? item.tx_byte : 8'h00;
						ack_n = item.send_ack;
						enter_p = PH_BIT_LOW;
					end
				end
			end
			default: begin
				if (step_q == PH_BIT_HIGH && cmd_q == CMD_READ && !item.scl_in) begin
					timer_n = timer_q;
				end else if (timer_q != '0) begin
					timer_n = timer_q - 1'b1;
				end else begin
					case (step_q)
						PH_ST_SCL_LOW, PH_SP_SDA_REL, PH_FINAL: begin
							if (step_q == PH_FINAL && cmd_q == CMD_READ) begin
								rx_n = shift_q;
							end
							step_n = PH_IDLE;
							done = 1'b1;
						end
						PH_BIT_HIGH: begin
							if (cmd_q == CMD_READ) begin
								shift_n = {shift_q[6:0], item.sda_in};
							end
							bits_n = bits_q + 1'b1;
							do_enter = 1'b1;
							enter_p = (bits_n >= 4'(BITS_PER_BYTE)) ? PH_ACK_LOW : PH_BIT_LOW;
						end
						PH_ACK_HIGH: begin
							if (cmd_q == CMD_WRITE) begin
								last_ack_n = item.sda_in;
							end
							do_enter = 1'b1;
							enter_p = PH_FINAL;
						end
						default: begin
							do_enter = 1'b1;
							enter_p = phase_t'(step_q + 1'b1);
						end
					endcase
				end
			end
		endcase
		if (do_enter) begin
			step_n = enter_p;
			timer_n = reload;
			drive_n = phase_drive(enter_p, cmd_n, shift_n, bits_n, ack_n, drive_q);
		end else begin
			drive_n = drive_q;
		end
	end

	always_comb begin
		res.scl_release = drive_n[1];
		res.sda_release = drive_n[0];
		res.busy_res    = (step_n != PH_IDLE);
		res.accepted    = acc;
		res.done_res    = done;
		res.rx_byte     = rx_n;
		res.ack_seen    = last_ack_n;
	end

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Bus-tick testbench for the I2C master byte engine. Clock ticks carrying
// commands and sampled line levels are driven from a queue, a behavioral
// copy of the phase sequencer predicts each tick's line drives and status,
// and every result is compared field by field. Several phase lengths are
// used, one of them changed while a command is still running.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import i2cm_pkg::*;

	typedef enum int {PACE_RX_SLOW, PACE_TX_SLOW, PACE_FULL} pace_t;

	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;
	localparam int STALL_LIMIT = 20000;
	localparam int PRINT_LIMIT = 50;

	logic clk = 1'b0;
	logic arst_n;

	i2cm_in_if  in_if();
	i2cm_out_if out_if();
	i2cm_cfg_if cfg_if();

	i2c_master_byte_engine u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_if),
		.out_ch (out_if),
		.cfg_ch (cfg_if)
	);

	in_item_t  tick_q[$];
	out_item_t bus_state_q[$];
	in_item_t  cur_tick;
	bit        in_fire;
	pace_t     pace;
	int        mismatches;
	int        stall_cycles;

	// Model of the phase sequencer.
	logic [15:0] m_half;
	phase_t      m_step;
	cmd_t        m_cmd;
	logic [3:0]  m_bits;
	logic [7:0]  m_shift;
	logic [15:0] m_timer;
	logic        m_ack_tx;
	logic [1:0]  m_lines;
	logic        m_ack_rx;
	logic [7:0]  m_rx_byte;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void load_phase(input phase_t p);
		logic [2:0] idx;
		idx = 3'd7 - m_bits[2:0];
		m_step = p;
		m_timer = (m_half == 16'd0) ? 16'd0 : m_half - 16'd1;
		case (p)
			PH_ST_SDA_REL, PH_SP_SDA_REL: m_lines[0] = 1'b1;
			PH_ST_SDA_LOW, PH_SP_SDA_LOW: m_lines[0] = 1'b0;
			PH_ST_SCL_REL, PH_SP_SCL_REL, PH_BIT_HIGH, PH_ACK_HIGH: m_lines[1] = 1'b1;
			PH_ST_SCL_LOW: m_lines[1] = 1'b0;
			PH_BIT_LOW: m_lines = {1'b0, (m_cmd == CMD_WRITE) ? m_shift[idx] : 1'b1};
			PH_ACK_LOW: m_lines = {1'b0, (m_cmd == CMD_READ) ? ~m_ack_tx : 1'b1};
			default: m_lines = 2'b01;
		endcase
	endfunction

	function automatic out_item_t sequence_tick(input in_item_t t);
		out_item_t r;
		logic      acc;
		logic      fin;
		phase_t    p;
		acc = 1'b0;
		fin = 1'b0;
		p = m_step;
		if (m_step == PH_IDLE) begin
			if (t.op >= CMD_START && t.op <= CMD_READ) begin
				acc = 1'b1;
				m_cmd = cmd_t'(t.op);
				if (m_cmd == CMD_START) begin
					load_phase(PH_ST_SDA_REL);
				end else if (m_cmd == CMD_STOP) begin
					load_phase(PH_SP_SDA_LOW);
				end else begin
					m_bits = 4'd0;
					m_shift = (m_cmd == CMD_WRITE) ? t.tx_byte : 8'h00;
					m_ack_tx = t.send_ack;
					load_phase(PH_BIT_LOW);
				end
			end
		end else if (m_step == PH_BIT_HIGH && m_cmd == CMD_READ && !t.scl_in) begin
			// The slave stretches the clock, so the phase timer holds.
		end else if (m_timer != 16'd0) begin
			m_timer = m_timer - 16'd1;
		end else if (p == PH_ST_SCL_LOW || p == PH_SP_SDA_REL || p >= PH_FINAL) begin
			if (p >= PH_FINAL && m_cmd == CMD_READ)
				m_rx_byte = m_shift;
			m_step = PH_IDLE;
			fin = 1'b1;
		end else if (p == PH_BIT_HIGH) begin
			if (m_cmd == CMD_READ)
				m_shift = {m_shift[6:0], t.sda_in};
			m_bits = m_bits + 4'd1;
			load_phase((m_bits >= BITS_PER_BYTE) ? PH_ACK_LOW : PH_BIT_LOW);
		end else if (p == PH_ACK_HIGH) begin
			if (m_cmd == CMD_WRITE)
				m_ack_rx = t.sda_in;
			load_phase(PH_FINAL);
		end else begin
			load_phase(phase_t'(p + 1));
		end
		r.scl_release = m_lines[1];
		r.sda_release = m_lines[0];
		r.busy_res = (m_step != PH_IDLE);
		r.accepted = acc;
		r.done_res = fin;
		r.rx_byte = m_rx_byte;
		r.ack_seen = m_ack_rx;
		return r;
	endfunction

	task automatic log_mismatch(input string what, input int got, input int want);
		if (mismatches < PRINT_LIMIT)
			$display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic check_result(input out_item_t got, input out_item_t want);
		if (got.scl_release !== want.scl_release)
			log_mismatch("scl_release", got.scl_release, want.scl_release);
		if (got.sda_release !== want.sda_release)
			log_mismatch("sda_release", got.sda_release, want.sda_release);
		if (got.busy_res !== want.busy_res)
			log_mismatch("busy_res", got.busy_res, want.busy_res);
		if (got.accepted !== want.accepted)
			log_mismatch("accepted", got.accepted, want.accepted);
		if (got.done_res !== want.done_res)
			log_mismatch("done_res", got.done_res, want.done_res);
		if (got.rx_byte !== want.rx_byte)
			log_mismatch("rx_byte", got.rx_byte, want.rx_byte);
		if (got.ack_seen !== want.ack_seen)
			log_mismatch("ack_seen", got.ack_seen, want.ack_seen);
	endtask

	function automatic bit hold_off(input int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic void add_tick(input logic [2:0] op, input logic [7:0] tx,
		input logic ack, input logic sda, input logic scl);
		in_item_t t;
		t.op = op;
		t.tx_byte = tx;
		t.send_ack = ack;
		t.sda_in = sda;
		t.scl_in = scl;
		tick_q.push_back(t);
	endfunction

	function automatic void add_bus_ticks(input int n, input bit with_cmds);
		int         pick;
		logic [2:0] op;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (!with_cmds || pick < 15)
				op = CMD_NONE;
			else if (pick < 85)
				op = 3'($urandom_range(CMD_START, CMD_READ));
			else
				op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
			add_tick(op, 8'($urandom), 1'($urandom), 1'($urandom),
				$urandom_range(99) < 85);
		end
	endfunction

	task automatic wait_drained();
		do @(negedge clk);
		while (tick_q.size() != 0 || in_if.valid || bus_state_q.size() != 0);
	endtask

	task automatic write_half_period(input logic [15:0] v);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data <= v;
		do @(posedge clk);
		while (!cfg_if.ready);
		m_half = v;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// Request driver and result ready driver.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_if.valid <= 1'b0;
		end else if (!in_if.valid || in_fire) begin
			if (tick_q.size() != 0 &&
				!hold_off(pace == PACE_RX_SLOW ? 17 : pace == PACE_TX_SLOW ? 55 : 0)) begin
				cur_tick = tick_q.pop_front();
				in_if.valid <= 1'b1;
				in_if.op <= cur_tick.op;
				in_if.tx_byte <= cur_tick.tx_byte;
				in_if.send_ack <= cur_tick.send_ack;
				in_if.sda_in <= cur_tick.sda_in;
				in_if.scl_in <= cur_tick.scl_in;
			end else begin
				in_if.valid <= 1'b0;
			end
		end
		out_if.ready <= !hold_off(pace == PACE_RX_SLOW ? 55 : pace == PACE_TX_SLOW ? 17 : 0);
	end

	// Monitor, predictor and watchdog.
	always @(posedge clk) begin
		out_item_t got;
		in_fire = in_if.valid && in_if.ready;
		if (in_fire)
			bus_state_q.push_back(sequence_tick(cur_tick));
		if (out_if.valid && out_if.ready) begin
			got.scl_release = out_if.scl_release;
			got.sda_release = out_if.sda_release;
			got.busy_res = out_if.busy_res;
			got.accepted = out_if.accepted;
			got.done_res = out_if.done_res;
			got.rx_byte = out_if.rx_byte;
			got.ack_seen = out_if.ack_seen;
			if (bus_state_q.size() == 0)
				log_mismatch("unexpected result, busy_res", got.busy_res, 0);
			else
				check_result(got, bus_state_q.pop_front());
		end
		if (in_fire || (out_if.valid && out_if.ready) || (cfg_if.valid && cfg_if.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("** i2c_master_byte_engine: FAILED **");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_if.valid = 1'b0;
		in_if.op = CMD_NONE;
		in_if.tx_byte = 8'h00;
		in_if.send_ack = 1'b0;
		in_if.sda_in = 1'b1;
		in_if.scl_in = 1'b1;
		out_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.data = 16'd0;
		pace = PACE_RX_SLOW;
		mismatches = 0;
		stall_cycles = 0;

		m_half = HALF_PERIOD_RESET;
		m_step = PH_IDLE;
		m_cmd = CMD_NONE;
		m_bits = 4'd0;
		m_shift = 8'h00;
		m_timer = 16'd0;
		m_ack_tx = 1'b0;
		m_lines = 2'b11;
		m_ack_rx = 1'b1;
		m_rx_byte = 8'h00;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_bus_ticks(40, 1'b1);
		wait_drained();

		write_half_period(16'd1);
		add_tick(CMD_NONE, 8'h00, 1'b0, 1'b1, 1'b1);
		for (logic [2:0] op = OP_UNUSED_LO; op <= OP_UNUSED_HI && op != 3'd0; op++)
			add_tick(op, 8'hFF, 1'b1, 1'b1, 1'b1);
		add_tick(CMD_START, 8'h00, 1'b0, 1'b1, 1'b1);
		add_tick(CMD_WRITE, 8'h3C, 1'b1, 1'b1, 1'b1);
		add_bus_ticks(4, 1'b0);
		add_tick(CMD_WRITE, 8'hFF, 1'b0, 1'b0, 1'b1);
		for (int i = 0; i < 20; i++)
			add_tick(CMD_NONE, 8'h00, 1'b0, 1'b0, 1'b1);
		add_tick(CMD_WRITE, 8'h00, 1'b1, 1'b1, 1'b0);
		for (int i = 0; i < 20; i++)
			add_tick(CMD_NONE, 8'hFF, 1'b1, 1'b1, 1'b0);
		add_tick(CMD_READ, 8'h00, 1'b1, 1'b0, 1'b1);
		add_bus_ticks(30, 1'b0);
		add_tick(CMD_READ, 8'hFF, 1'b0, 1'b1, 1'b1);
		add_bus_ticks(30, 1'b0);
		add_tick(CMD_STOP, 8'h00, 1'b0, 1'b1, 1'b1);
		add_bus_ticks(4, 1'b0);
		add_bus_ticks(60, 1'b1);
		wait_drained();

		pace = PACE_TX_SLOW;
		write_half_period(16'd2);
		add_bus_ticks(80, 1'b1);
		wait_drained();
		write_half_period(16'd3);
		add_bus_ticks(60, 1'b1);
		wait_drained();

		pace = PACE_FULL;
		write_half_period(16'd60);
		add_tick(CMD_WRITE, 8'($urandom), 1'b0, 1'b1, 1'b1);
		add_bus_ticks(3, 1'b0);
		wait_drained();
		write_half_period(16'd1);
		add_bus_ticks(80, 1'b0);
		wait_drained();
		write_half_period(16'd4);
		add_bus_ticks(60, 1'b1);
		wait_drained();

		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("** i2c_master_byte_engine: PASSED **");
		else
			$display("** i2c_master_byte_engine: FAILED **");
		$finish;
	end

endmodule

/* files.f */
src/i2cm_pkg.sv
src/i2cm_ifs.sv
src/i2cm_core.sv
src/i2c_master_byte_engine.sv
tb/sv/tb_top.sv
